>>> hw/rtl/arm_pkg.sv
// Shared types, constants and the microcode program of the address range map table.
package arm_pkg;

   // Table geometry.
   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   // Reset values of the mapping window.
   localparam logic [31:0] WINDOW_LOW_RESET  = 32'h6000_0000;
   localparam logic [31:0] WINDOW_HIGH_RESET = 32'h8000_0000;

   // Page rounding.
   localparam logic [31:0] PAGE_MASK = 32'd4095;

   // Request kinds.
   localparam logic [1:0] MODE_MAP    = 2'd0;
   localparam logic [1:0] MODE_UNMAP  = 2'd1;
   localparam logic [1:0] MODE_LOOKUP = 2'd2;

   // Result status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_REQ   = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_WINDOW    = 3'd3;
   localparam logic [2:0] ST_UNALIGNED = 3'd4;
   localparam logic [2:0] ST_OVERLAP   = 3'd5;
   localparam logic [2:0] ST_NOT_FOUND = 3'd6;

   // Configuration register indexes.
   localparam logic REG_WINDOW_LOW  = 1'b0;
   localparam logic REG_WINDOW_HIGH = 1'b1;

   // Microcode step addresses.
   typedef logic [1:0] step_type;
   localparam step_type STEP_IDLE   = 2'd0;
   localparam step_type STEP_SCAN   = 2'd1;
   localparam step_type STEP_WAIT   = 2'd2;
   localparam step_type STEP_COMMIT = 2'd3;

   // Jump conditions: when the condition holds the sequencer jumps to the target,
   // otherwise it falls through to the next step.
   typedef enum logic [1:0] {
      COND_NO_REQ,
      COND_SCAN_MORE,
      COND_OUT_BUSY,
      COND_ALWAYS
   } cond_type;

   // One control word of the program.
   typedef struct packed {
      logic     ready;
      logic     scan;
      logic     commit;
      cond_type cond;
      step_type target;
   } ctl_word_type;

   // Datapath status that the sequencer branches on.
   typedef struct packed {
      logic req_valid;
      logic scan_last;
      logic out_busy;
   } seq_flags_type;

   // The program: wait for a request, scan every entry, wait for a free output
   // register, then commit the result and any table update.
   function automatic ctl_word_type ucode_rom(step_type step);
      ctl_word_type w;
      w = '0;
      unique case (step)
         STEP_IDLE: begin
            w.ready  = 1'b1;
            w.cond   = COND_NO_REQ;
            w.target = STEP_IDLE;
         end
         STEP_SCAN: begin
            w.scan   = 1'b1;
            w.cond   = COND_SCAN_MORE;
            w.target = STEP_SCAN;
         end
         STEP_WAIT: begin
            w.cond   = COND_OUT_BUSY;
            w.target = STEP_WAIT;
         end
         STEP_COMMIT: begin
            w.commit = 1'b1;
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

>>> hw/rtl/address_range_map_table.sv
// Top level of the address range map table: handshakes, window registers, sequencer and datapath.
//
// Usage: a request transaction (req_mode, req_request_addr, req_request_length,
// req_fixed_request) is accepted on req_valid with req_stall low. Map places a
// region in the lowest free slot, unmap frees the region starting at the
// address, and lookup tells whether the address lies in a mapped region.
// Every request yields exactly one response transaction on the rsp_ channel.
// Sequence: a request is accepted in the idle step, the table is then scanned
// one entry per cycle, followed by the wait step, which holds while the output
// register is full, and the commit step, which loads the response. A new request
// is taken only back in the idle step, after the previous one has been committed.
// The entry scan reads the table through its single read port, one entry at a time.
// Stall: the response sits in an output register; a new request may be
// accepted while it waits, but that request holds in the wait step until the
// previous response is taken.
// Reset clears all valid bits and the entry count and loads the window
// registers with their defaults. The user must write the window registers through the
// csr_ port only while the block is idle; the block itself does not enforce this.
module address_range_map_table (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_request_addr,
   input  logic [30:0] req_request_length,
   input  logic        req_fixed_request,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_result_addr,
   output logic [19:0] rsp_page_count,
   output logic [4:0]  rsp_entry_count,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   arm_pkg::ctl_word_type  ctl;
   arm_pkg::seq_flags_type flags;
   logic                   req_accept;
   logic                   scan_last;
   logic                   out_busy;
   logic [31:0]            window_low_ff;
   logic [31:0]            window_high_ff;
   logic                   csr_write;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_low_ff  <= arm_pkg::WINDOW_LOW_RESET;
         window_high_ff <= arm_pkg::WINDOW_HIGH_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == arm_pkg::REG_WINDOW_LOW) begin
            window_low_ff <= csr_pwdata;
         end else begin
            window_high_ff <= csr_pwdata;
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == arm_pkg::REG_WINDOW_HIGH) ? window_high_ff
                                                                  : window_low_ff;

   // Requests are taken only in the idle step of the program.
   assign req_stall  = !ctl.ready;
   assign req_accept = req_valid && ctl.ready;

   assign flags.req_valid = req_valid;
   assign flags.scan_last = scan_last;
   assign flags.out_busy  = out_busy;

   arm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   arm_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .req_accept         (req_accept),
      .req_mode           (req_mode),
      .req_request_addr   (req_request_addr),
      .req_request_length (req_request_length),
      .req_fixed_request  (req_fixed_request),
      .window_low         (window_low_ff),
      .window_high        (window_high_ff),
      .rsp_stall          (rsp_stall),
      .scan_last          (scan_last),
      .out_busy           (out_busy),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_result_addr    (rsp_result_addr),
      .rsp_page_count     (rsp_page_count),
      .rsp_entry_count    (rsp_entry_count)
   );

endmodule

>>> hw/rtl/arm_seq.sv
// Microcode sequencer: step counter, program table and conditional jumps.
module arm_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  arm_pkg::seq_flags_type flags,
   output arm_pkg::ctl_word_type  ctl
);

   arm_pkg::step_type pc_ff;
   arm_pkg::step_type pc_in;
   logic              take_jump;

   // Fetch the control word of the current step.
   assign ctl = arm_pkg::ucode_rom(pc_ff);

   // Evaluate the jump condition of this step.
   always_comb begin
      unique case (ctl.cond)
         arm_pkg::COND_NO_REQ:    take_jump = !flags.req_valid;
         arm_pkg::COND_SCAN_MORE: take_jump = !flags.scan_last;
         arm_pkg::COND_OUT_BUSY:  take_jump = flags.out_busy;
         arm_pkg::COND_ALWAYS:    take_jump = 1'b1;
         default:                 take_jump = 1'b1;
      endcase
      pc_in = take_jump ? ctl.target : pc_ff + 2'd1;
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= arm_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

>>> hw/rtl/arm_dp.sv
// Datapath: region table, entry scan, status decision and the result register.
module arm_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  arm_pkg::ctl_word_type  ctl,
   input  logic                   req_accept,
   input  logic [1:0]             req_mode,
   input  logic [31:0]            req_request_addr,
   input  logic [30:0]            req_request_length,
   input  logic                   req_fixed_request,
   input  logic [31:0]            window_low,
   input  logic [31:0]            window_high,
   input  logic                   rsp_stall,
   output logic                   scan_last,
   output logic                   out_busy,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_status,
   output logic [31:0]            rsp_result_addr,
   output logic [19:0]            rsp_page_count,
   output logic [4:0]             rsp_entry_count
);

   localparam int IDX_W = arm_pkg::IDX_W;
   localparam int CNT_W = arm_pkg::CNT_W;
   localparam int NENT  = arm_pkg::ENTRIES;

   // Region table; entry contents count only while the entry's valid bit is set.
   logic [31:0]      region_start_ff  [NENT];
   logic [30:0]      region_length_ff [NENT];
   logic [NENT-1:0]  region_valid_ff;
   logic [CNT_W-1:0] valid_count_ff;

   // Captured transaction.
   logic [1:0]       mode_ff;
   logic [31:0]      addr_ff;
   logic [30:0]      len_ff;
   logic             fixed_ff;
   logic [32:0]      new_end_ff;
   logic [19:0]      pages_ff;
   logic [31:0]      len_round;

   // Scan state.
   logic [IDX_W-1:0] idx_ff;
   logic             free_found_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic             match_found_ff;
   logic [IDX_W-1:0] match_idx_ff;
   logic             overlap_ff;
   logic             contain_ff;

   // Result register.
   logic             rsp_valid_ff;
   logic [2:0]       rsp_status_ff;
   logic [31:0]      rsp_result_addr_ff;
   logic [19:0]      rsp_page_count_ff;
   logic [4:0]       rsp_entry_count_ff;

   // Per-entry compare of the scan.
   logic [31:0]      rd_start;
   logic [32:0]      rd_end;
   logic             rd_valid;
   logic             below_end;
   logic             ent_overlap;
   logic             ent_contain;
   logic             ent_match;

   // Decision.
   logic [2:0]       status;
   logic             do_map;
   logic             do_unmap;

   assign len_round = {1'b0, req_request_length} + arm_pkg::PAGE_MASK;

   // Compare the request against the entry under the scan index.
   always_comb begin
      rd_start    = region_start_ff[idx_ff];
      rd_end      = {1'b0, rd_start} + {2'b00, region_length_ff[idx_ff]};
      rd_valid    = region_valid_ff[idx_ff];
      below_end   = {1'b0, addr_ff} < rd_end;
      ent_overlap = rd_valid && below_end && ({1'b0, rd_start} < new_end_ff);
      ent_contain = rd_valid && below_end && (addr_ff >= rd_start);
      ent_match   = rd_valid && (rd_start == addr_ff);
   end

   assign scan_last = (idx_ff == IDX_W'(NENT - 1));

   // Map checks go in priority order; unmap and lookup use the scan summary.
   always_comb begin
      do_map   = 1'b0;
      do_unmap = 1'b0;
      unique case (mode_ff)
         arm_pkg::MODE_MAP: begin
            priority if (len_ff == '0 || !fixed_ff) begin
               status = arm_pkg::ST_BAD_REQ;
            end else if (!free_found_ff) begin
               status = arm_pkg::ST_FULL;
            end else if (addr_ff > window_high || addr_ff < window_low) begin
               status = arm_pkg::ST_WINDOW;
            end else if (addr_ff[11:0] != 12'd0) begin
               status = arm_pkg::ST_UNALIGNED;
            end else if (overlap_ff) begin
               status = arm_pkg::ST_OVERLAP;
            end else begin
               status = arm_pkg::ST_OK;
               do_map = 1'b1;
            end
         end
         arm_pkg::MODE_UNMAP: begin
            status   = match_found_ff ? arm_pkg::ST_OK : arm_pkg::ST_NOT_FOUND;
            do_unmap = match_found_ff;
         end
         arm_pkg::MODE_LOOKUP: begin
            status = contain_ff ? arm_pkg::ST_OK : arm_pkg::ST_NOT_FOUND;
         end
         default: begin
            status = arm_pkg::ST_NOT_FOUND;
         end
      endcase
   end

   // Request capture and the entry scan.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff         <= '0;
         free_found_ff  <= 1'b0;
         match_found_ff <= 1'b0;
         overlap_ff     <= 1'b0;
         contain_ff     <= 1'b0;
      end else if (req_accept) begin
         idx_ff         <= '0;
         free_found_ff  <= 1'b0;
         match_found_ff <= 1'b0;
         overlap_ff     <= 1'b0;
         contain_ff     <= 1'b0;
      end else if (ctl.scan) begin
         idx_ff <= idx_ff + 1'b1;
         if (!rd_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
         if (ent_match && !match_found_ff) begin
            match_found_ff <= 1'b1;
         end
         overlap_ff <= overlap_ff | ent_overlap;
         contain_ff <= contain_ff | ent_contain;
      end
   end

   // Payload of the captured transaction and the scan indexes.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff    <= req_mode;
         addr_ff    <= req_request_addr;
         len_ff     <= req_request_length;
         fixed_ff   <= req_fixed_request;
         new_end_ff <= {1'b0, req_request_addr} + {2'b00, req_request_length};
         pages_ff   <= len_round[31:12];
      end
      if (ctl.scan) begin
         if (!rd_valid && !free_found_ff) begin
            free_idx_ff <= idx_ff;
         end
         if (ent_match && !match_found_ff) begin
            match_idx_ff <= idx_ff;
         end
      end
   end

   // Table contents are written only on a successful map.
   always_ff @(posedge clock) begin
      if (ctl.commit && do_map) begin
         region_start_ff[free_idx_ff]  <= addr_ff;
         region_length_ff[free_idx_ff] <= len_ff;
      end
   end

   // Valid bits and the entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         region_valid_ff <= '0;
         valid_count_ff  <= '0;
      end else if (ctl.commit) begin
         if (do_map) begin
            region_valid_ff[free_idx_ff] <= 1'b1;
            valid_count_ff               <= valid_count_ff + 1'b1;
         end else if (do_unmap) begin
            region_valid_ff[match_idx_ff] <= 1'b0;
            valid_count_ff                <= valid_count_ff - 1'b1;
         end
      end
   end

   // Result register: loaded at commit, freed when the transaction is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_status_ff <= status;
         if (mode_ff == arm_pkg::MODE_MAP) begin
            rsp_result_addr_ff <= do_map ? addr_ff : '1;
         end else begin
            rsp_result_addr_ff <= '0;
         end
         rsp_page_count_ff <= do_map ? pages_ff : '0;
         if (do_map) begin
            rsp_entry_count_ff <= 5'(valid_count_ff + 1'b1);
         end else if (do_unmap) begin
            rsp_entry_count_ff <= 5'(valid_count_ff - 1'b1);
         end else begin
            rsp_entry_count_ff <= 5'(valid_count_ff);
         end
      end
   end

   assign out_busy        = rsp_valid_ff && rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_addr = rsp_result_addr_ff;
   assign rsp_page_count  = rsp_page_count_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule
